[design/smx_pkg.sv]
// ----------------------------------------------------------------------------
// smx_pkg
// Shared widths, operation and register codes, and the mix hand-off type
// for the one-shot sample voice mixer.
// ----------------------------------------------------------------------------
package smx_pkg;

	// payload widths
	localparam int SAMPLE_W  = 16;
	localparam int POS_W     = 13;
	localparam int PERIOD_W  = 17;
	localparam int LEVEL_W   = 16;
	localparam int COUNT_W   = 3;
	localparam int SUM_W     = 18;
	localparam int OP_W      = 2;
	localparam int VOICE_W   = 2;
	localparam int ADDR_W    = 12;
	localparam int CFG_IDX_W = 3;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd2;

	// register indexes: period, then one length per voice
	localparam int REG_PWM_PERIOD = 0;
	localparam int REG_LENGTH0    = 1;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd2834;

	// ceil(2^17 / 3), exact floor division by three below 2^17
	localparam logic [16:0] RECIP3 = 17'd43691;

	// mix saturation bounds
	localparam logic signed [SUM_W-1:0] MIX_MAX = 18'sd32767;
	localparam logic signed [SUM_W-1:0] MIX_MIN = -18'sd32768;

	// accumulated sum of one tick and number of contributing voices
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [COUNT_W-1:0]      count;
	} mix_t;

endpackage

[design/one_shot_sample_voice_mixer.sv]
// ----------------------------------------------------------------------------
// one_shot_sample_voice_mixer: one-shot PCM voices mixed to a PWM level
// Trigger and load take effect on their transfer; a tick walks the voices,
// one voice per cycle through the sample read port.
// A new item is taken once the tick has left for the output register.
// Reset stops voices, clears lengths, restores the period; samples are kept.
// ----------------------------------------------------------------------------
module one_shot_sample_voice_mixer #(
	parameter int VOICE_COUNT = 4,
	parameter int CLIP_DEPTH  = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [smx_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smx_pkg::PERIOD_W-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [smx_pkg::OP_W-1:0]            operation,
	input  logic [smx_pkg::VOICE_W-1:0]         voice,
	input  logic [smx_pkg::ADDR_W-1:0]          address,
	input  logic signed [smx_pkg::SAMPLE_W-1:0] sample_word,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [smx_pkg::LEVEL_W-1:0]         level,
	output logic [smx_pkg::COUNT_W-1:0]         voices_mixed
);
	import smx_pkg::*;

	localparam int MEM_DEPTH = VOICE_COUNT * CLIP_DEPTH;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int VIDX_W    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

	logic [PERIOD_W-1:0] period_q;
	logic [POS_W-1:0]    length_q [VOICE_COUNT];

	logic              in_xfer;
	logic              voice_ok;
	logic              addr_ok;
	logic              tick_start;
	logic              trig;
	logic              load_we;
	logic [VIDX_W-1:0] voice_idx;
	logic [MEM_AW-1:0] load_addr;
	logic              rd_en;
	logic [MEM_AW-1:0] rd_addr;
	logic [SAMPLE_W-1:0] rd_data;
	logic              voice_busy;
	logic              level_busy;
	logic              mix_valid;
	mix_t              mix;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				length_q[v] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_IDX_W'(REG_PWM_PERIOD)) begin
				period_q <= cfg_data;
			end
			for (int v = 0; v < VOICE_COUNT; v++) begin
				if (cfg_index == CFG_IDX_W'(REG_LENGTH0 + v)) begin
					length_q[v] <= cfg_data[POS_W-1:0];
				end
			end
		end
	end

	// input transfer decode
	assign in_ready   = !voice_busy && !level_busy;
	assign in_xfer    = in_valid && in_ready;
	assign voice_ok   = {1'b0, voice} < (VOICE_W + 1)'(VOICE_COUNT);
	assign addr_ok    = PERIOD_W'(address) < PERIOD_W'(CLIP_DEPTH);
	assign tick_start = in_xfer && (operation == OP_TICK);
	assign trig       = in_xfer && (operation == OP_TRIGGER) && voice_ok;
	assign load_we    = in_xfer && (operation == OP_LOAD) && voice_ok && addr_ok;
	assign voice_idx  = VIDX_W'(voice);
	assign load_addr  = MEM_AW'(voice_idx) * MEM_AW'(CLIP_DEPTH) + MEM_AW'(address);

	smx_store #(
		.DEPTH (MEM_DEPTH),
		.AW    (MEM_AW)
	) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (load_addr),
		.wdata (sample_word),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	smx_voice #(
		.VOICE_COUNT (VOICE_COUNT),
		.CLIP_DEPTH  (CLIP_DEPTH),
		.MEM_AW      (MEM_AW),
		.VIDX_W      (VIDX_W)
	) u_voice (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_start (tick_start),
		.trig       (trig),
		.trig_voice (voice_idx),
		.length     (length_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    ($signed(rd_data)),
		.busy       (voice_busy),
		.mix_valid  (mix_valid),
		.mix        (mix)
	);

	smx_level u_level (
		.clk          (clk),
		.arst_n       (arst_n),
		.mix_valid    (mix_valid),
		.mix          (mix),
		.period       (period_q),
		.busy         (level_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level        (level),
		.voices_mixed (voices_mixed)
	);

endmodule

[design/smx_store.sv]
// ----------------------------------------------------------------------------
// smx_store
// Sample memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smx_store #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [smx_pkg::SAMPLE_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [smx_pkg::SAMPLE_W-1:0] rdata
);
	import smx_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/smx_voice.sv]
// ----------------------------------------------------------------------------
// smx_voice
// Voice state and tick scan: walks the voices one per cycle, reads the next
// sample of each playing voice and accumulates the sum and voice count.
// ----------------------------------------------------------------------------
module smx_voice #(
	parameter int VOICE_COUNT = 4,
	parameter int CLIP_DEPTH  = 4096,
	parameter int MEM_AW      = 14,
	parameter int VIDX_W      = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tick_start,
	input  logic                               trig,
	input  logic [VIDX_W-1:0]                  trig_voice,
	input  logic [smx_pkg::POS_W-1:0]          length [VOICE_COUNT],
	output logic                               rd_en,
	output logic [MEM_AW-1:0]                  rd_addr,
	input  logic signed [smx_pkg::SAMPLE_W-1:0] rd_data,
	output logic                               busy,
	output logic                               mix_valid,
	output smx_pkg::mix_t                      mix
);
	import smx_pkg::*;

	logic [VOICE_COUNT-1:0] active_q;
	logic [POS_W-1:0]       pos_q [VOICE_COUNT];
	logic                   scan_q;
	logic [VIDX_W-1:0]      vidx_q;
	logic                   take_s1;
	logic                   last_s1;
	logic                   done_q;
	logic signed [SUM_W-1:0] acc_q;
	logic [COUNT_W-1:0]     cnt_q;

	logic [POS_W-1:0] len_eff;
	logic [POS_W-1:0] pos_cur;
	logic [POS_W-1:0] pos_next;
	logic             take;
	logic             last_voice;

	// current voice: clip length limited to the clip depth
	always_comb begin
		if (32'(length[vidx_q]) > 32'(CLIP_DEPTH)) begin
			len_eff = POS_W'(CLIP_DEPTH);
		end else begin
			len_eff = length[vidx_q];
		end
		pos_cur    = pos_q[vidx_q];
		pos_next   = pos_cur + 1'b1;
		take       = scan_q && active_q[vidx_q] && (pos_cur < len_eff);
		last_voice = (vidx_q == VIDX_W'(VOICE_COUNT - 1));
	end

	// sample read for a playing voice
	assign rd_en   = take;
	assign rd_addr = MEM_AW'(vidx_q) * MEM_AW'(CLIP_DEPTH) + MEM_AW'(pos_cur);

	// voice state and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				pos_q[v] <= '0;
			end
			scan_q  <= 1'b0;
			vidx_q  <= '0;
			take_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (trig) begin
				pos_q[trig_voice]    <= '0;
				active_q[trig_voice] <= 1'b1;
			end
			if (tick_start) begin
				scan_q <= 1'b1;
				vidx_q <= '0;
			end else if (scan_q) begin
				if (last_voice) begin
					scan_q <= 1'b0;
				end
				vidx_q <= vidx_q + 1'b1;
			end
			if (take) begin
				pos_q[vidx_q] <= pos_next;
				if (pos_next >= len_eff) begin
					active_q[vidx_q] <= 1'b0;
				end
			end
			take_s1 <= take;
			last_s1 <= scan_q && last_voice;
			done_q  <= last_s1;
		end
	end

	// accumulate returning samples
	always_ff @(posedge clk) begin
		if (tick_start) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (take_s1) begin
			acc_q <= acc_q + SUM_W'(rd_data);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign mix.sum   = acc_q;
	assign mix.count = cnt_q;
	assign mix_valid = done_q;
	assign busy      = scan_q | take_s1 | last_s1 | done_q;

endmodule

[design/smx_level.sv]
// ----------------------------------------------------------------------------
// smx_level
// Mix to PWM level: divide by voice count, saturate, offset, scale by the
// period and clamp; holds the result in an output register.
// ----------------------------------------------------------------------------
module smx_level (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              mix_valid,
	input  smx_pkg::mix_t                     mix,
	input  logic [smx_pkg::PERIOD_W-1:0]      period,
	output logic                              busy,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [smx_pkg::LEVEL_W-1:0]       level,
	output logic [smx_pkg::COUNT_W-1:0]       voices_mixed
);
	import smx_pkg::*;

	localparam int PROD3_W = SUM_W + 17;
	localparam int PROD_W  = LEVEL_W + PERIOD_W;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic out_valid_q;

	logic                    neg_s1, neg_s2;
	logic [SUM_W-1:0]        mag_s1;
	logic [SUM_W-1:0]        quot_s2;
	logic [LEVEL_W-1:0]      u_s3;
	logic [PROD_W-1:0]       prod_s4;
	logic [COUNT_W-1:0]      cnt_s1, cnt_s2, cnt_s3, cnt_s4;
	logic [LEVEL_W-1:0]      level_q;
	logic [COUNT_W-1:0]      count_q;

	logic [PROD3_W-1:0]      prod3;
	logic [SUM_W-1:0]        quot;
	logic signed [SUM_W-1:0] sval;
	logic signed [SUM_W-1:0] clamped;
	logic [PERIOD_W-1:0]     lvl_raw;
	logic [PERIOD_W-1:0]     lvl_clip;
	logic [LEVEL_W-1:0]      lvl;
	logic                    load_out;

	// stage control; stage 4 waits for a free output register
	assign load_out = valid_s4 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= mix_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (valid_s3) begin
				valid_s4 <= 1'b1;
			end else if (load_out) begin
				valid_s4 <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divide by count: shifts for two and four, reciprocal for three
	always_comb begin
		prod3 = PROD3_W'(mag_s1) * PROD3_W'(RECIP3);
		case (cnt_s1)
			3'd2:    quot = mag_s1 >> 1;
			3'd3:    quot = prod3[PROD3_W-1 -: SUM_W];
			3'd4:    quot = mag_s1 >> 2;
			default: quot = mag_s1;
		endcase
	end

	// restore sign and saturate to 16 bits
	always_comb begin
		sval = neg_s2 ? -$signed(quot_s2) : $signed(quot_s2);
		if (sval > MIX_MAX) begin
			clamped = MIX_MAX;
		end else if (sval < MIX_MIN) begin
			clamped = MIX_MIN;
		end else begin
			clamped = sval;
		end
	end

	// scaled level, clamped below the period and to 16 bits
	always_comb begin
		lvl_raw = prod_s4[PROD_W-1 -: PERIOD_W];
		if (period == '0) begin
			lvl_clip = '0;
		end else if (lvl_raw >= period) begin
			lvl_clip = period - 1'b1;
		end else begin
			lvl_clip = lvl_raw;
		end
		if (lvl_clip > PERIOD_W'({LEVEL_W{1'b1}})) begin
			lvl = {LEVEL_W{1'b1}};
		end else begin
			lvl = lvl_clip[LEVEL_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (mix_valid) begin
			neg_s1 <= mix.sum[SUM_W-1];
			mag_s1 <= mix.sum[SUM_W-1] ? SUM_W'(-mix.sum) : SUM_W'(mix.sum);
			cnt_s1 <= mix.count;
		end
		if (valid_s1) begin
			neg_s2  <= neg_s1;
			quot_s2 <= quot;
			cnt_s2  <= cnt_s1;
		end
		if (valid_s2) begin
			u_s3   <= {~clamped[LEVEL_W-1], clamped[LEVEL_W-2:0]};
			cnt_s3 <= cnt_s2;
		end
		if (valid_s3) begin
			prod_s4 <= PROD_W'(u_s3) * PROD_W'(period);
			cnt_s4  <= cnt_s3;
		end
		if (load_out) begin
			level_q <= lvl;
			count_q <= cnt_s4;
		end
	end

	assign busy         = valid_s1 | valid_s2 | valid_s3 | valid_s4;
	assign out_valid    = out_valid_q;
	assign level        = level_q;
	assign voices_mixed = count_q;

endmodule
